### rtl/svadsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svadsr_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SAMPLE_RATE     = 48000;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PITCH_COUNT     = 128;

  localparam logic [24:0] LEVEL_ONE = 25'h100_0000;

  localparam int MUL_AW = 42;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW + 1);

  localparam logic [63:0] STEP_DIV = 64'(SAMPLE_RATE) << (33 - PHASE_BITS);

  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608594974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  typedef logic [PHASE_BITS-1:0] step_tab_t [PITCH_COUNT];

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_GAIN    = 3'd1,
    CFG_ATTACK  = 3'd2,
    CFG_DECAY   = 3'd3,
    CFG_SUSTAIN = 3'd4,
    CFG_RELEASE = 3'd5,
    CFG_LFO_STEP  = 3'd6,
    CFG_LFO_DEPTH = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
  } env_stage_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_Y2, S_M, S_T, S_R, S_ENV, S_GAIN, S_DEPTH, S_FAC, S_OUT
  } state_t;

  // equal-tempered phase step per midi note
  function automatic step_tab_t build_steps();
    step_tab_t   tab;
    logic [63:0] num;
    int          q;
    for (int i = 0; i < PITCH_COUNT; i++) begin
      q = i + 3;
      num = (64'd55 * 64'(SEMITONE_Q30[q % 12])) << (q / 12);
      tab[i] = PHASE_BITS'((num + STEP_DIV / 2) / STEP_DIV);
    end
    return tab;
  endfunction

  localparam step_tab_t STEP_TAB = build_steps();

endpackage
`default_nettype wire

### rtl/synth_voice_adsr_lfo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// monophonic synth voice with adsr envelope and sine lfo
// item channel: item_valid/item_stall carry operation and pitch
//   (0 sample tick, 1 note on, 2 note off, 3 ignored)
// sample channel: sample_valid/sample_stall carry audio_sample, one word
//   per sample tick, signed and saturated
// config port: cfg_write, cfg_index, cfg_data; write only while idle
// note on, note off and ignored words give no word
// a sample tick runs n = 2 to 12 multiplies on one
//   bit-serial shift-add multiplier (25 steps per multiply):
//   2 for square/triangle/saw, 6 with sine wave, 6 more with the lfo
// the multiplier is the loop that sets the rate; one word at a time
// item_stall is high while a tick is in progress
// a finished word sits in the output register; if sample_stall holds it,
//   the next tick waits at its final step, with item_stall high
// reset: registers at defaults, envelope idle, phases zero, no word out
module synth_voice_adsr_lfo_core #(
  parameter int SAMPLE_BITS = svadsr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [24:0]            cfg_data,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [1:0]             operation,
  input  wire logic [6:0]             pitch,
  output logic                        sample_valid,
  input  wire logic                   sample_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_sample
);
  import svadsr_pkg::*;

  localparam int SH = 56 - SAMPLE_BITS;
  localparam int MW = SAMPLE_BITS + 2;
  localparam logic [MW-1:0] POS_MAX = MW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [MW-1:0] NEG_MAG = MW'(1 << (SAMPLE_BITS - 1));

  logic [2:0]  mode;
  logic [15:0] output_gain;
  logic [24:0] attack_step, decay_step, sustain_level, release_step;
  logic [23:0] lfo_step;
  logic [15:0] lfo_depth;

  logic [PHASE_BITS-1:0] wave_phase, wave_step;
  logic [23:0]           lfo_phase;
  logic [24:0]           env_level;
  env_stage_t            env_stage;

  state_t state, state_next;
  logic   issued, mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  logic [16:0]       sy, s_mag, w_mag, r_val;
  logic [15:0]       y2, mm, tt;
  logic              sin_neg, sin_lfo, s_neg, w_neg, m_neg, fac_neg;
  logic [MUL_AW-1:0] a_mag;
  logic [MW-1:0]     m_mag;
  logic [16:0]       fac_mag;

  logic       accept, out_free, load_out;
  logic [24:0] sus_eff;
  logic [25:0] att_sum;
  logic [14:0] p15;
  logic [MUL_PW-1:0] rnd_gain, rnd_depth, rnd_fac;
  logic [17:0] fac_sum;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  assign accept   = item_valid && !item_stall;
  assign out_free = !sample_valid || !sample_stall;
  assign load_out = (state == S_OUT) && out_free;
  assign sus_eff  = (sustain_level > LEVEL_ONE) ? LEVEL_ONE : sustain_level;
  assign att_sum  = {1'b0, env_level} + {1'b0, attack_step};
  assign p15      = wave_phase[PHASE_BITS-1 -: 15];

  assign rnd_gain  = mul_p + (MUL_PW'(1) << (SH - 1));
  assign rnd_depth = mul_p + (MUL_PW'(1) << 14);
  assign rnd_fac   = mul_p + (MUL_PW'(1) << 15);

  svadsr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && operation == OP_TICK) state_next = S_START;
      S_START: begin
        if (mode[1:0] == WAVE_SINE) state_next = S_Y2;
        else state_next = S_ENV;
      end
      S_Y2:    if (mul_done) state_next = S_M;
      S_M:     if (mul_done) state_next = S_T;
      S_T:     if (mul_done) state_next = S_R;
      S_R:     if (mul_done) state_next = sin_lfo ? S_DEPTH : S_ENV;
      S_ENV:   if (mul_done) state_next = S_GAIN;
      S_GAIN:  if (mul_done) state_next = mode[2] ? S_Y2 : S_OUT;
      S_DEPTH: if (mul_done) state_next = S_FAC;
      S_FAC:   if (mul_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    item_stall = (state != S_IDLE);
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_Y2:    begin mul_a = MUL_AW'(sy);    mul_b = MUL_BW'(sy);          end
      S_M:     begin mul_a = MUL_AW'(2320);  mul_b = MUL_BW'(y2);          end
      S_T:     begin mul_a = MUL_AW'(mm);    mul_b = MUL_BW'(y2);          end
      S_R:     begin mul_a = MUL_AW'(tt);    mul_b = MUL_BW'(sy);          end
      S_ENV:   begin mul_a = MUL_AW'(w_mag); mul_b = MUL_BW'(env_level);   end
      S_GAIN:  begin mul_a = a_mag;          mul_b = MUL_BW'(output_gain); end
      S_DEPTH: begin mul_a = MUL_AW'(s_mag); mul_b = MUL_BW'(lfo_depth);   end
      S_FAC:   begin mul_a = MUL_AW'(m_mag); mul_b = MUL_BW'(fac_mag);     end
      default: begin mul_a = '0;             mul_b = '0;                   end
    endcase
    case (state)
      S_Y2, S_M, S_T, S_R, S_ENV, S_GAIN, S_DEPTH, S_FAC: mul_start = !issued;
      default: mul_start = 1'b0;
    endcase
  end

  // lfo factor and saturation
  always_comb begin
    fac_sum = 18'd32768 + {1'b0, r_val};
    if (m_neg) begin
      sat_val = (m_mag > NEG_MAG) ? SAMPLE_BITS'(NEG_MAG)
                                  : -SAMPLE_BITS'(m_mag);
      if (m_mag > NEG_MAG) sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = (m_mag > POS_MAX) ? SAMPLE_BITS'(POS_MAX) : SAMPLE_BITS'(m_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) issued <= 1'b1;
      else if (mul_done) issued <= 1'b0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 3'd0;
      output_gain   <= 16'd19661;
      attack_step   <= 25'd1024;
      decay_step    <= 25'd1024;
      sustain_level <= 25'd8388608;
      release_step  <= 25'd1024;
      lfo_step      <= 24'd0;
      lfo_depth     <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:      mode          <= cfg_data[2:0];
        CFG_GAIN:      output_gain   <= cfg_data[15:0];
        CFG_ATTACK:    attack_step   <= cfg_data;
        CFG_DECAY:     decay_step    <= cfg_data;
        CFG_SUSTAIN:   sustain_level <= cfg_data;
        CFG_RELEASE:   release_step  <= cfg_data;
        CFG_LFO_STEP:  lfo_step      <= cfg_data[23:0];
        CFG_LFO_DEPTH: lfo_depth     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_phase <= '0;
      wave_step  <= '0;
      lfo_phase  <= '0;
      env_level  <= '0;
      env_stage  <= ENV_IDLE;
    end else if (state == S_IDLE && accept) begin
      case (operation)
        OP_NOTE_ON: begin
          wave_step  <= STEP_TAB[pitch];
          wave_phase <= '0;
          env_level  <= '0;
          env_stage  <= ENV_ATTACK;
        end
        OP_NOTE_OFF: begin
          if (env_stage inside {ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE}) begin
            env_level <= sus_eff;
            env_stage <= ENV_RELEASE;
          end
        end
        default: ;
      endcase
    end else if (load_out) begin
      wave_phase <= wave_phase + wave_step;
      lfo_phase  <= lfo_phase + lfo_step;
      case (env_stage)
        ENV_ATTACK: begin
          if (att_sum >= {1'b0, LEVEL_ONE}) begin
            env_level <= LEVEL_ONE;
            env_stage <= ENV_DECAY;
          end else begin
            env_level <= att_sum[24:0];
          end
        end
        ENV_DECAY: begin
          if (env_level > sus_eff && (env_level - sus_eff) > decay_step) begin
            env_level <= env_level - decay_step;
          end else begin
            env_level <= sus_eff;
            env_stage <= ENV_SUSTAIN;
          end
        end
        ENV_SUSTAIN: env_level <= sus_eff;
        ENV_RELEASE: begin
          if (env_level > release_step) begin
            env_level <= env_level - release_step;
          end else begin
            env_level <= '0;
            env_stage <= ENV_IDLE;
          end
        end
        default: begin
          env_level <= '0;
          env_stage <= ENV_IDLE;
        end
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    case (state)
      S_START: begin
        sin_lfo <= 1'b0;
        sin_neg <= wave_phase[PHASE_BITS-1];
        sy <= wave_phase[PHASE_BITS-2] ? 17'd32768 - {2'b0, wave_phase[PHASE_BITS-3 -: 8], 7'd0}
                                       : {2'b0, wave_phase[PHASE_BITS-3 -: 8], 7'd0};
        case (mode[1:0])
          WAVE_SQUARE: begin
            w_neg <= 1'b0;
            w_mag <= (wave_phase <= (PHASE_BITS'(1) << (PHASE_BITS - 1))) ? 17'd32768 : 17'd0;
          end
          WAVE_TRIANGLE: begin
            if (p15 < 15'd16384) begin
              w_neg <= 1'b0;
              w_mag <= 17'd32768 - {2'b0, p15};
            end else begin
              w_neg <= 1'b1;
              w_mag <= 17'd32768 - {2'b0, p15};
            end
          end
          WAVE_SAW: begin
            if (p15 <= 15'd16384) begin
              w_neg <= 1'b0;
              w_mag <= 17'd32768 - {1'b0, p15, 1'b0};
            end else begin
              w_neg <= 1'b1;
              w_mag <= {1'b0, p15, 1'b0} - 17'd32768;
            end
          end
          default: begin
            w_neg <= 1'b0;
            w_mag <= '0;
          end
        endcase
      end
      S_Y2: if (mul_done) y2 <= mul_p[30:15];
      S_M:  if (mul_done) mm <= 16'd21024 - mul_p[30:15];
      S_T:  if (mul_done) tt <= 16'd51472 - mul_p[30:15];
      S_R: begin
        if (mul_done) begin
          if (sin_lfo) begin
            s_mag <= mul_p[31:15];
            s_neg <= sin_neg;
          end else begin
            w_mag <= mul_p[31:15];
            w_neg <= sin_neg;
          end
        end
      end
      S_ENV: if (mul_done) a_mag <= mul_p[MUL_AW-1:0];
      S_GAIN: begin
        if (mul_done) begin
          m_mag   <= MW'(rnd_gain >> SH);
          m_neg   <= w_neg;
          sin_lfo <= 1'b1;
          sin_neg <= lfo_phase[23];
          sy <= lfo_phase[22] ? 17'd32768 - {2'b0, lfo_phase[21:14], 7'd0}
                              : {2'b0, lfo_phase[21:14], 7'd0};
        end
      end
      S_DEPTH: begin
        if (mul_done) r_val <= rnd_depth[31:15];
      end
      S_FAC: begin
        if (mul_done) begin
          m_mag <= MW'(rnd_fac >> 16);
          m_neg <= m_neg ^ fac_neg;
        end
      end
      default: ;
    endcase
  end

  // factor 0.5 + depth*sin, kept as sign and magnitude
  always_comb begin
    fac_neg = 1'b0;
    fac_mag = fac_sum[16:0];
    if (s_neg) begin
      if (r_val > 17'd32768) begin
        fac_neg = 1'b1;
        fac_mag = r_val - 17'd32768;
      end else begin
        fac_mag = 17'd32768 - r_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (load_out) begin
      sample_valid <= 1'b1;
    end else if (sample_valid && !sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) audio_sample <= sat_val;
  end

`ifndef ASSERT_OFF
  a_word_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(state) == S_OUT) else $error("word without a finished tick");
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_TICK) |=> state == S_START) else $error("tick not started");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    env_level <= LEVEL_ONE) else $error("envelope above full scale");
  a_mul_only_busy: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state != S_IDLE && state != S_OUT && state != S_START))
    else $error("multiply result outside a multiply step");
`endif

endmodule
`default_nettype wire

### rtl/svadsr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module svadsr_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [svadsr_pkg::MUL_AW-1:0] a,
  input  wire logic [svadsr_pkg::MUL_BW-1:0] b,
  output logic                              done,
  output logic      [svadsr_pkg::MUL_PW-1:0] p
);
  import svadsr_pkg::*;

  logic [MUL_PW-1:0] prod;
  logic [MUL_CW-1:0] cnt;
  logic              busy;
  logic [MUL_AW:0]   sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {1'b0, prod[MUL_PW-1:MUL_BW]} + {1'b0, (prod[0] ? a : MUL_AW'(0))};
  assign p   = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CW'(MUL_BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {MUL_AW'(0), b};
    end else if (busy) begin
      prod <= {sum, prod[MUL_BW-1:1]};
    end
  end

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("product without a running multiply");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !(cnt == MUL_CW'(1)) |=> busy) else $error("multiply ended early");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0)) else $error("step count ran out while busy");
`endif

endmodule
`default_nettype wire

### verif/synth_voice_adsr_lfo_checker.sv
`timescale 1ns / 1ps
module synth_voice_adsr_lfo_checker
  import svadsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [1:0]         operation,
  input  logic [6:0]         pitch,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  logic signed [15:0] audio_sample,
  output int                 errors,
  output int                 pending
);

  logic [2:0]  mode_r;
  logic [15:0] gain_r;
  logic [24:0] attack_r, decay_r, sustain_r, release_r;
  logic [23:0] lfo_step_r;
  logic [15:0] lfo_depth_r;

  logic [23:0] wave_phase, wave_step, lfo_phase;
  logic [31:0] env_level;
  env_stage_t  env_stage;

  logic [15:0] sample_q [$];
  int          err_cnt;

  function automatic int sine_of(logic [23:0] ph);
    logic [9:0]        idx;
    longint unsigned   y, y2, m, t;
    int                v;
    idx = ph[23:14];
    y = longint'(idx[7:0]) << 7;
    if (idx[8]) y = 32768 - y;
    y2 = (y * y) >> 15;
    m = 21024 - ((2320 * y2) >> 15);
    t = 51472 - ((m * y2) >> 15);
    v = int'((t * y) >> 15);
    return idx[9] ? -v : v;
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [23:0] note_step(logic [6:0] p);
    int              q;
    longint unsigned num, dv;
    q = int'(p) + 3;
    num = (64'd55 * 64'(SEMITONE_Q30[q % 12])) << (q / 12);
    dv = 64'd48000 << 9;
    return 24'((num + dv / 2) / dv);
  endfunction

  function automatic int osc_value();
    int p15;
    p15 = int'(wave_phase[23:9]);
    case (wave_t'(mode_r[1:0]))
      WAVE_SINE:     return sine_of(wave_phase);
      WAVE_SQUARE:   return (wave_phase <= 24'h80_0000) ? 32768 : 0;
      WAVE_TRIANGLE: return (p15 < 16384) ? 32768 - p15 : p15 - 32768;
      default:       return 32768 - 2 * p15;
    endcase
  endfunction

  function automatic logic [31:0] sustain_clamped();
    return (sustain_r > LEVEL_ONE) ? 32'(LEVEL_ONE) : 32'(sustain_r);
  endfunction

  function automatic logic [15:0] next_sample();
    longint m, fac;
    m = round_away(longint'(osc_value()) * longint'(env_level) * longint'(gain_r), 40);
    if (mode_r[2]) begin
      fac = 32768 + round_away(longint'(lfo_depth_r) * longint'(sine_of(lfo_phase)), 15);
      m = round_away(m * fac, 16);
    end
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return 16'(m);
  endfunction

  task automatic advance_voice();
    logic [31:0] sus;
    sus = sustain_clamped();
    wave_phase = wave_phase + wave_step;
    lfo_phase = lfo_phase + lfo_step_r;
    case (env_stage)
      ENV_ATTACK: begin
        env_level = env_level + attack_r;
        if (env_level >= LEVEL_ONE) begin
          env_level = LEVEL_ONE;
          env_stage = ENV_DECAY;
        end
      end
      ENV_DECAY: begin
        if (env_level > sus && env_level - sus > decay_r) begin
          env_level = env_level - decay_r;
        end else begin
          env_level = sus;
          env_stage = ENV_SUSTAIN;
        end
      end
      ENV_SUSTAIN: env_level = sus;
      ENV_RELEASE: begin
        if (env_level > release_r) begin
          env_level = env_level - release_r;
        end else begin
          env_level = 0;
          env_stage = ENV_IDLE;
        end
      end
      default: begin
        env_level = 0;
        env_stage = ENV_IDLE;
      end
    endcase
  endtask

  always @(posedge clk) begin
    logic [15:0] exp_word;
    if (rst) begin
      mode_r = 0;
      gain_r = 16'd19661;
      attack_r = 25'd1024;
      decay_r = 25'd1024;
      sustain_r = 25'd8388608;
      release_r = 25'd1024;
      lfo_step_r = 0;
      lfo_depth_r = 0;
      wave_phase = 0;
      wave_step = 0;
      lfo_phase = 0;
      env_level = 0;
      env_stage = ENV_IDLE;
      sample_q.delete();
      err_cnt = 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        if (sample_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, actual %0d", $time, audio_sample);
        end else begin
          exp_word = sample_q.pop_front();
          if (exp_word !== audio_sample) begin
            err_cnt++;
            $display("%0t: audio_sample mismatch, expected %0d actual %0d", $time,
                     $signed(exp_word), audio_sample);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:      mode_r = cfg_data[2:0];
          CFG_GAIN:      gain_r = cfg_data[15:0];
          CFG_ATTACK:    attack_r = cfg_data;
          CFG_DECAY:     decay_r = cfg_data;
          CFG_SUSTAIN:   sustain_r = cfg_data;
          CFG_RELEASE:   release_r = cfg_data;
          CFG_LFO_STEP:  lfo_step_r = cfg_data[23:0];
          CFG_LFO_DEPTH: lfo_depth_r = cfg_data[15:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        case (operation)
          OP_TICK: begin
            sample_q.push_back(next_sample());
            advance_voice();
          end
          OP_NOTE_ON: begin
            wave_step = note_step(pitch);
            wave_phase = 0;
            env_level = 0;
            env_stage = ENV_ATTACK;
          end
          OP_NOTE_OFF: begin
            if (env_stage inside {ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE}) begin
              env_level = sustain_clamped();
              env_stage = ENV_RELEASE;
            end
          end
          default: ;
        endcase
      end
    end
    errors <= err_cnt;
    pending <= sample_q.size();
  end

endmodule

### verif/synth_voice_adsr_lfo_core_tb.sv
`timescale 1ns / 1ps
module synth_voice_adsr_lfo_core_tb;
  import svadsr_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [24:0]        cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         operation;
  logic [6:0]         pitch;
  logic               sample_valid;
  logic               sample_stall;
  logic signed [15:0] audio_sample;
  int                 errors;
  int                 pending;

  int burst_left;
  int idle_cycles;
  int items_sent;

  synth_voice_adsr_lfo_core u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .pitch(pitch),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .audio_sample(audio_sample)
  );

  synth_voice_adsr_lfo_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .pitch(pitch),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .audio_sample(audio_sample),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int cyc;
    int style;
    cyc = 0;
    style = 0;
    sample_stall = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 250 == 0) style = $urandom_range(0, 3);
      if (cyc >= 6000 && cyc < 6700) sample_stall <= 1'b1;
      else case (style)
        0: sample_stall <= 1'b0;
        1: sample_stall <= ($urandom_range(0, 1) == 1);
        2: sample_stall <= ($urandom_range(0, 9) != 0);
        default: sample_stall <= ((cyc / 3) % 2 == 1);
      endcase
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (sample_valid && !sample_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(op_t op, logic [6:0] p);
    item_valid <= 1'b1;
    operation <= op;
    pitch <= p;
    do @(posedge clk); while (item_stall);
    if (op != 2'd3) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [24:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic logic [24:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 25'd0;
      1: return 25'h1FF_FFFF;
      2: return 25'h100_0000;
      default: return 25'($urandom_range(0, 32'h1FF_FFFF) >> $urandom_range(4, 18));
    endcase
  endfunction

  task automatic load_settings(int k);
    logic [24:0] sus;
    case ($urandom_range(0, 4))
      0: sus = 25'h1FF_FFFF;
      1: sus = 25'd0;
      2: sus = 25'h100_0000;
      default: sus = 25'($urandom_range(0, 32'h1FF_FFFF));
    endcase
    write_reg(CFG_MODE, 25'(k % 8));
    write_reg(CFG_GAIN, (k % 5 == 0) ? 25'hFFFF : (k % 5 == 1) ? 25'd0 :
                        25'($urandom_range(0, 16'hFFFF)));
    write_reg(CFG_ATTACK, pick_step());
    write_reg(CFG_DECAY, pick_step());
    write_reg(CFG_SUSTAIN, sus);
    write_reg(CFG_RELEASE, pick_step());
    write_reg(CFG_LFO_STEP, (k % 3 == 0) ? 25'hFF_FFFF : 25'($urandom_range(0, 24'hFF_FFFF)));
    write_reg(CFG_LFO_DEPTH, (k % 4 == 0) ? 25'hFFFF : (k % 4 == 1) ? 25'd0 :
                             25'($urandom_range(0, 16'hFFFF)));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int k, n;
    rst = 1;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    item_valid = 0;
    operation = 0;
    pitch = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 5;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first, then extremes
    send_word(OP_NOTE_OFF, 7'd0);
    send_word(op_t'(2'd3), 7'h7F);
    send_word(OP_TICK, 7'd0);
    send_word(OP_NOTE_ON, 7'd0);
    repeat (2) send_word(OP_TICK, 7'd0);
    drain();
    write_reg(CFG_MODE, 25'd4);
    write_reg(CFG_GAIN, 25'hFFFF);
    write_reg(CFG_ATTACK, 25'h80_0000);
    write_reg(CFG_DECAY, 25'h40_0000);
    write_reg(CFG_SUSTAIN, 25'h40_0000);
    write_reg(CFG_RELEASE, 25'h30_0000);
    write_reg(CFG_LFO_STEP, 25'hFF_FFFF);
    write_reg(CFG_LFO_DEPTH, 25'hFFFF);
    cfg_write <= 1'b0;
    send_word(OP_NOTE_ON, 7'd127);
    repeat (3) send_word(OP_TICK, 7'd0);
    drain();
    write_reg(CFG_SUSTAIN, 25'h1FF_FFFF);
    write_reg(CFG_MODE, 25'd3);
    cfg_write <= 1'b0;
    repeat (2) send_word(OP_TICK, 7'd0);
    send_word(OP_NOTE_OFF, 7'd0);
    repeat (2) send_word(OP_TICK, 7'd0);
    send_word(OP_NOTE_ON, 7'd69);
    send_word(OP_NOTE_OFF, 7'd0);
    repeat (3) send_word(OP_TICK, 7'd0);
    drain();

    // random phases of well-formed notes with some noise
    k = 0;
    while (items_sent < 1450) begin
      load_settings(k);
      k++;
      n = 0;
      while (n < 36) begin
        if ($urandom_range(0, 9) < 8) begin
          send_word(OP_NOTE_ON, 7'($urandom_range(0, 127)));
          repeat ($urandom_range(1, 12)) begin
            send_word(OP_TICK, 7'($urandom_range(0, 127)));
            n++;
          end
          if ($urandom_range(0, 3) != 0) send_word(OP_NOTE_OFF, 7'($urandom_range(0, 127)));
          repeat ($urandom_range(0, 8)) begin
            send_word(OP_TICK, 7'($urandom_range(0, 127)));
            n++;
          end
          n += 2;
        end else begin
          send_word(op_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
          n++;
        end
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
